@@ sv/lsos_pkg.sv @@
// ----------------------------------------------------------------------------
// lsos_pkg: shared types and constants for the lidar sector obstacle steer
// Command, configuration and action types, sector pattern codes, and the
// steering decision function.
// ----------------------------------------------------------------------------
package lsos_pkg;

  // field widths fixed by the sample and result formats
  localparam int POS_W    = 5;
  localparam int DIST_W   = 16;
  localparam int SECTOR_W = 5;
  localparam int ACTION_W = 3;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_NEAR_LIMIT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AVG_LIMIT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP_DISTANCE = 2'd2;

  localparam logic [DIST_W-1:0] NEAR_LIMIT_RST    = 16'd25;
  localparam logic [DIST_W-1:0] AVG_LIMIT_RST     = 16'd150;
  localparam logic [DIST_W-1:0] STOP_DISTANCE_RST = 16'd35;

  // position register value meaning no position seen yet
  localparam logic [POS_W-1:0] POS_NONE = 5'd31;

  // command queue depth between front and back
  localparam int FIFO_DEPTH = 2;

  // sector pattern codes
  localparam int SECTOR_COUNT = 5;
  localparam logic [SECTOR_W-1:0] PAT_BLOCK_A  = 5'h17;
  localparam logic [SECTOR_W-1:0] PAT_BLOCK_B  = 5'h15;
  localparam logic [SECTOR_W-1:0] PAT_BLOCK_C  = 5'h1d;
  localparam logic [SECTOR_W-1:0] PAT_BLOCK_D  = 5'h1f;
  localparam logic [SECTOR_W-1:0] MASK_CENTER  = 5'h0e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_STOP_BACK = 3'd1,
    ACT_FORWARD   = 3'd2,
    ACT_LEFT      = 3'd3,
    ACT_RIGHT     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CMD_IDLE = 2'd0,
    CMD_FILL = 2'd1,
    CMD_PROC = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [POS_W-1:0]   pos;
    logic [DIST_W-1:0]  distance;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] near_limit;
    logic [DIST_W-1:0] avg_limit;
    logic [DIST_W-1:0] stop_distance;
  } cfg_t;

  // steering choice from sector pattern and stop condition
  function automatic action_t lsos_choose(logic [SECTOR_W-1:0] p, logic at_stop);
    action_t act;
    if (p == PAT_BLOCK_A || p == PAT_BLOCK_B || p == PAT_BLOCK_C ||
        p == PAT_BLOCK_D || at_stop) begin
      act = ACT_STOP_BACK;
    end else if ((p & MASK_CENTER) == '0) begin
      act = ACT_FORWARD;
    end else if ({1'b0, p[4:3]} >= p[2:0]) begin
      act = ACT_LEFT;
    end else begin
      act = ACT_RIGHT;
    end
    return act;
  endfunction

endpackage

@@ sv/lsos_in_if.sv @@
// ----------------------------------------------------------------------------
// lsos_in_if: sample channel
// Valid/ready channel carrying one scan position and its distance.
// ----------------------------------------------------------------------------
interface lsos_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  scan_position;
  logic [15:0] distance;

  modport source (output valid, output scan_position, output distance, input ready);
  modport sink (input valid, input scan_position, input distance, output ready);
endinterface

@@ sv/lsos_out_if.sv @@
// ----------------------------------------------------------------------------
// lsos_out_if: result channel
// Valid/ready channel carrying one steering result per sample.
// ----------------------------------------------------------------------------
interface lsos_out_if;
  logic        valid;
  logic        ready;
  logic        scan_valid;
  logic [15:0] nearest;
  logic        cold_zone;
  logic [4:0]  sector_bits;
  logic [2:0]  action;

  modport source (output valid, output scan_valid, output nearest, output cold_zone,
                  output sector_bits, output action, input ready);
  modport sink (input valid, input scan_valid, input nearest, input cold_zone,
                input sector_bits, input action, output ready);
endinterface

@@ sv/lidar_sector_obstacle_steer.sv @@
// ----------------------------------------------------------------------------
// lidar_sector_obstacle_steer: obstacle detection and steering from a lidar
// Flow: a sample in the fill phase, a repeat or an out-of-range slot passes
//   through the command queue to a registered idle result; a full-store
//   sample walks the window in ST_WALK and its result is registered in ST_DONE.
// Throughput: the single compare and add unit walks the window one slot per
//   cycle, so no new command is taken until the full-store result is registered;
//   idle and fill samples pass at one per cycle while the result channel is free.
// Reset: synchronous, active low; restores register defaults and clears the
//   distance store, near bits and fill state at once, no clearing pass.
// ----------------------------------------------------------------------------
module lidar_sector_obstacle_steer #(
  parameter int SLOT_COUNT   = 20,
  parameter int WINDOW_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  lsos_in_if.sink                             in_ch,
  lsos_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsos_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lsos_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lsos_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import lsos_pkg::*;

  cfg_t                   cfg_r, cfg_nxt;
  logic                   cfg_write;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   push_valid, push_ready;
  cmd_t                   push_data;
  logic                   pop_valid, pop;
  cmd_t                   pop_data;

  // register file
  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      case (reg_idx)
        REG_NEAR_LIMIT:    cfg_nxt.near_limit    = pwdata[DIST_W-1:0];
        REG_AVG_LIMIT:     cfg_nxt.avg_limit     = pwdata[DIST_W-1:0];
        REG_STOP_DISTANCE: cfg_nxt.stop_distance = pwdata[DIST_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NEAR_LIMIT:    prdata = CFG_DATA_W'(cfg_r.near_limit);
      REG_AVG_LIMIT:     prdata = CFG_DATA_W'(cfg_r.avg_limit);
      REG_STOP_DISTANCE: prdata = CFG_DATA_W'(cfg_r.stop_distance);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit    <= NEAR_LIMIT_RST;
      cfg_r.avg_limit     <= AVG_LIMIT_RST;
      cfg_r.stop_distance <= STOP_DISTANCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sample classifier
  lsos_front #(
    .SLOT_COUNT   (SLOT_COUNT),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // command queue
  lsos_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  // window evaluator
  lsos_back #(
    .SLOT_COUNT   (SLOT_COUNT),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_data  (pop_data),
    .cmd_pop   (pop),
    .cfg       (cfg_r),
    .out_ch    (out_ch)
  );

endmodule

@@ sv/lsos_fifo.sv @@
// ----------------------------------------------------------------------------
// lsos_fifo: command queue
// Small register queue that decouples sample classification from execution.
// ----------------------------------------------------------------------------
module lsos_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lsos_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output lsos_pkg::cmd_t pop_data
);
  import lsos_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/lsos_front.sv @@
// ----------------------------------------------------------------------------
// lsos_front: sample classifier
// Accepts samples, marks repeats and out-of-range slots as idle, tracks the fill
// phase and queues a command for each accepted sample.
// ----------------------------------------------------------------------------
module lsos_front #(
  parameter int SLOT_COUNT   = 20,
  parameter int WINDOW_WIDTH = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  lsos_in_if.sink        in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output lsos_pkg::cmd_t push_data
);
  import lsos_pkg::*;

  localparam int SKIP      = (SLOT_COUNT - WINDOW_WIDTH) / 2;
  localparam int WIN_SLOTS = SLOT_COUNT - 2 * SKIP;
  localparam int FILL_W    = $clog2(WIN_SLOTS + 1);

  logic [POS_W-1:0]  prev_pos_r, prev_pos_nxt;
  logic [FILL_W-1:0] fill_count_r, fill_count_nxt;
  logic              store_full_r, store_full_nxt;
  logic              accept;
  logic              skip_sample;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  // repeat of last slot or slot beyond the store
  assign skip_sample = (in_ch.scan_position == prev_pos_r) ||
                       ({1'b0, in_ch.scan_position} >= (POS_W + 1)'(SLOT_COUNT));

  // classify and advance the fill phase
  always_comb begin
    prev_pos_nxt       = prev_pos_r;
    fill_count_nxt     = fill_count_r;
    store_full_nxt     = store_full_r;
    push_data.pos      = in_ch.scan_position;
    push_data.distance = in_ch.distance;
    push_data.kind     = CMD_PROC;
    if (skip_sample) begin
      push_data.kind = CMD_IDLE;
    end else begin
      if (accept) begin
        prev_pos_nxt = in_ch.scan_position;
      end
      if (!store_full_r) begin
        if (fill_count_r < FILL_W'(WIN_SLOTS)) begin
          push_data.kind = CMD_FILL;
          if (accept) begin
            fill_count_nxt = fill_count_r + 1'b1;
          end
        end else if (accept) begin
          store_full_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pos_r   <= POS_NONE;
      fill_count_r <= '0;
      store_full_r <= 1'b0;
    end else begin
      prev_pos_r   <= prev_pos_nxt;
      fill_count_r <= fill_count_nxt;
      store_full_r <= store_full_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= FILL_W'(WIN_SLOTS))
    else $error("fill count beyond window size");

  a_full_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    store_full_r |-> fill_count_r == FILL_W'(WIN_SLOTS))
    else $error("store marked full before fill phase completed");

endmodule

@@ sv/lsos_back.sv @@
// ----------------------------------------------------------------------------
// lsos_back: window evaluator
// Writes samples to the distance store, walks the window with one shared
// compare and add unit, folds near bits into sectors and picks the action.
// ----------------------------------------------------------------------------
module lsos_back #(
  parameter int SLOT_COUNT   = 20,
  parameter int WINDOW_WIDTH = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  lsos_pkg::cmd_t cmd_data,
  output logic           cmd_pop,
  input  lsos_pkg::cfg_t cfg,
  lsos_out_if.source     out_ch
);
  import lsos_pkg::*;

  localparam int SKIP      = (SLOT_COUNT - WINDOW_WIDTH) / 2;
  localparam int WIN_SLOTS = SLOT_COUNT - 2 * SKIP;
  localparam int WIN_END   = SLOT_COUNT - SKIP;
  localparam int SPAN      = WINDOW_WIDTH / SECTOR_COUNT;
  localparam int INNER_MIN = 2 * (SPAN / 2);
  localparam int IDX_W     = $clog2(SLOT_COUNT);
  localparam int SUM_W     = DIST_W + $clog2(WIN_SLOTS);
  localparam int CMP_W     = SUM_W + 1;
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(SKIP);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WIN_END - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t          state_r, state_nxt;
  logic [DIST_W-1:0]    store_r [SLOT_COUNT];
  logic [DIST_W-1:0]    store_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] near_r, near_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DIST_W-1:0]    min_r, min_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 zone_r, zone_nxt;
  logic [SECTOR_W-1:0]  sector_r, sector_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_scan_valid_r, out_scan_valid_nxt;
  logic [DIST_W-1:0]    out_nearest_r, out_nearest_nxt;
  logic                 out_cold_r, out_cold_nxt;
  logic [SECTOR_W-1:0]  out_sector_r, out_sector_nxt;
  action_t              out_action_r, out_action_nxt;

  logic                 out_free;
  logic [IDX_W-1:0]     wr_idx;
  logic [DIST_W-1:0]    rd_dist;
  logic [2:0]           sec_cnt [SECTOR_COUNT];
  logic [SECTOR_W-1:0]  pattern;
  logic [CMP_W-1:0]     zone_thr;
  logic                 zone_cold;
  logic                 at_stop;

  assign out_free = !out_valid_r || out_ch.ready;
  assign wr_idx   = cmd_data.pos[IDX_W-1:0];
  assign rd_dist  = store_r[idx_r];

  // near bits folded into five sectors
  always_comb begin
    for (int k = 0; k < SECTOR_COUNT; k++) begin
      sec_cnt[k] = '0;
      for (int i = 0; i < SPAN; i++) begin
        sec_cnt[k] = sec_cnt[k] + 3'(near_r[SKIP + k * SPAN + i]);
      end
    end
    pattern[4] = (sec_cnt[0] != '0);
    pattern[3] = (sec_cnt[1] >= 3'(INNER_MIN));
    pattern[2] = (sec_cnt[2] >= 3'(INNER_MIN));
    pattern[1] = (sec_cnt[3] >= 3'(INNER_MIN));
    pattern[0] = (sec_cnt[4] != '0);
  end

  // average above limit: sum >= (limit + 1) * width
  assign zone_thr  = CMP_W'((32'(cfg.avg_limit) + 32'd1) * 32'(WINDOW_WIDTH));
  assign zone_cold = !(CMP_W'(sum_r) < zone_thr);
  assign at_stop   = (min_r <= cfg.stop_distance);

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    store_nxt          = store_r;
    near_nxt           = near_r;
    idx_nxt            = idx_r;
    min_nxt            = min_r;
    sum_nxt            = sum_r;
    zone_nxt           = zone_r;
    sector_nxt         = sector_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_scan_valid_nxt = out_scan_valid_r;
    out_nearest_nxt    = out_nearest_r;
    out_cold_nxt       = out_cold_r;
    out_sector_nxt     = out_sector_r;
    out_action_nxt     = out_action_r;
    cmd_pop            = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_data.kind == CMD_PROC) begin
            cmd_pop           = 1'b1;
            store_nxt[wr_idx] = cmd_data.distance;
            near_nxt[wr_idx]  = (cmd_data.distance < cfg.near_limit);
            idx_nxt           = IDX_FIRST;
            min_nxt           = '1;
            sum_nxt           = '0;
            state_nxt         = ST_WALK;
          end else if (out_free) begin
            // idle result, store written during the fill phase
            cmd_pop = 1'b1;
            if (cmd_data.kind == CMD_FILL) begin
              store_nxt[wr_idx] = cmd_data.distance;
            end
            out_valid_nxt      = 1'b1;
            out_scan_valid_nxt = 1'b0;
            out_nearest_nxt    = '0;
            out_cold_nxt       = zone_r;
            out_sector_nxt     = sector_r;
            out_action_nxt     = ACT_NONE;
          end
        end
      end
      ST_WALK: begin
        min_nxt = (rd_dist < min_r) ? rd_dist : min_r;
        sum_nxt = sum_r + SUM_W'(rd_dist);
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          zone_nxt           = zone_cold;
          sector_nxt         = pattern;
          out_valid_nxt      = 1'b1;
          out_scan_valid_nxt = 1'b1;
          out_nearest_nxt    = min_r;
          out_cold_nxt       = zone_cold;
          out_sector_nxt     = pattern;
          out_action_nxt     = lsos_choose(pattern, at_stop);
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      near_r      <= '0;
      zone_r      <= 1'b0;
      sector_r    <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        store_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      near_r      <= near_nxt;
      zone_r      <= zone_nxt;
      sector_r    <= sector_nxt;
      out_valid_r <= out_valid_nxt;
      store_r     <= store_nxt;
    end
  end

  // walk accumulators and result payload
  always_ff @(posedge clk) begin
    idx_r            <= idx_nxt;
    min_r            <= min_nxt;
    sum_r            <= sum_nxt;
    out_scan_valid_r <= out_scan_valid_nxt;
    out_nearest_r    <= out_nearest_nxt;
    out_cold_r       <= out_cold_nxt;
    out_sector_r     <= out_sector_nxt;
    out_action_r     <= out_action_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scan_valid  = out_scan_valid_r;
  assign out_ch.nearest     = out_nearest_r;
  assign out_ch.cold_zone   = out_cold_r;
  assign out_ch.sector_bits = out_sector_r;
  assign out_ch.action      = out_action_r;

  a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> (idx_r >= IDX_FIRST && idx_r <= IDX_LAST))
    else $error("walk index outside scan window");

  a_idle_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_scan_valid_r) |->
      (out_nearest_r == '0 && out_action_r == ACT_NONE))
    else $error("idle result carries nearest or action");

endmodule

@@ test/lidar_sector_obstacle_steer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sector_obstacle_steer_test: self-checking bench for the lidar steer
// Streams scan samples through the sample channel while a local predictor
// keeps its own distance store, near flags and fill state. Every steering
// result is checked field by field in order. The run steps through several
// register settings and handshake idling patterns, including a long result
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module lidar_sector_obstacle_steer_test;
  import lsos_pkg::*;

  // block geometry at default parameters
  localparam int SLOTS     = 20;
  localparam int WINDOW    = 20;
  localparam int SKIP      = (SLOTS - WINDOW) / 2;
  localparam int WIN_SLOTS = SLOTS - 2 * SKIP;
  localparam int SPAN      = WINDOW / 5;

  // sector masks for the left/right steering choice
  localparam logic [SECTOR_W-1:0] LEFT_MASK  = 5'h1c;
  localparam logic [SECTOR_W-1:0] RIGHT_MASK = 5'h07;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = WIN_SLOTS + 8;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [DIST_W-1:0] distance;
  } scan_item_t;

  typedef struct {
    logic              scan_valid;
    logic [DIST_W-1:0] nearest;
    logic              cold_zone;
    logic [SECTOR_W-1:0] sectors;
    action_t           action;
  } steer_result_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  lsos_in_if  in_ch ();
  lsos_out_if out_ch ();

  lidar_sector_obstacle_steer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and expectation stores
  scan_item_t    scan_queue[$];
  steer_result_t expected_steer[$];
  int unsigned   err_count = 0;

  // idling control
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_request   = 1'b0;
  logic        hold_taken     = 1'b0;
  int unsigned hold_left      = 0;

  // predictor copy of the registers
  logic [DIST_W-1:0] secure_dist = NEAR_LIMIT_RST;
  logic [DIST_W-1:0] hot_limit   = AVG_LIMIT_RST;
  logic [DIST_W-1:0] stop_dist   = STOP_DISTANCE_RST;

  // predictor copy of the block state
  logic [DIST_W-1:0]   dist_store[SLOTS];
  logic                near_flag[SLOTS];
  int unsigned         fill_count = 0;
  logic                store_full = 1'b0;
  logic [POS_W-1:0]    last_pos   = POS_NONE;
  logic                zone_q     = 1'b0;
  logic [SECTOR_W-1:0] sectors_q  = '0;

  // sweep generator state
  int          sweep_pos = 0;
  logic        sweep_up  = 1'b1;
  logic [4:0]  near_mask = '0;
  logic [POS_W-1:0] gen_last = '0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      dist_store[i] = '0;
      near_flag[i]  = 1'b0;
    end
  end

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("lidar_sector_obstacle_steer_test: done, errors");
    $finish;
  end

  // steering choice from sector pattern and nearest distance
  function automatic action_t pick_action(logic [SECTOR_W-1:0] pat, logic [DIST_W-1:0] low);
    if (pat == PAT_BLOCK_A || pat == PAT_BLOCK_B || pat == PAT_BLOCK_C ||
        pat == PAT_BLOCK_D || low <= stop_dist) return ACT_STOP_BACK;
    if ((pat & MASK_CENTER) == '0) return ACT_FORWARD;
    if (((pat & LEFT_MASK) >> 3) >= (pat & RIGHT_MASK)) return ACT_LEFT;
    return ACT_RIGHT;
  endfunction

  // expected result of one accepted sample, updating the local state
  function automatic steer_result_t steer_predict(logic [POS_W-1:0] pos,
                                                  logic [DIST_W-1:0] sample_dist);
    steer_result_t r;
    logic [DIST_W-1:0] low;
    logic [SECTOR_W-1:0] pat;
    int unsigned total;
    int unsigned cnt;
    logic flag;
    r.scan_valid = 1'b0;
    r.nearest    = '0;
    r.cold_zone  = zone_q;
    r.sectors    = sectors_q;
    r.action     = ACT_NONE;
    // repeats and slots beyond the store change nothing
    if (pos == last_pos || pos >= SLOTS) return r;
    last_pos = pos;
    dist_store[pos] = sample_dist;
    // still filling the window
    if (!store_full) begin
      if (fill_count < WIN_SLOTS) begin
        fill_count++;
        return r;
      end
      store_full = 1'b1;
    end
    // minimum and average over the window
    low   = dist_store[SKIP];
    total = 0;
    for (int i = SKIP; i < SLOTS - SKIP; i++) begin
      if (dist_store[i] < low) low = dist_store[i];
      total += 32'(dist_store[i]);
    end
    zone_q = (total / WINDOW <= hot_limit) ? 1'b0 : 1'b1;
    near_flag[pos] = (sample_dist < secure_dist);
    // fold near flags into sectors, outer ones by any, inner by count
    pat = '0;
    for (int k = 0; k < 5; k++) begin
      cnt = 0;
      for (int i = 0; i < SPAN; i++) cnt += 32'(near_flag[SKIP + k * SPAN + i]);
      if (k == 0 || k == 4) flag = (cnt != 0);
      else flag = (cnt / (SPAN / 2)) > 1;
      pat[4 - k] = flag;
    end
    sectors_q = pat;
    r.scan_valid = 1'b1;
    r.nearest    = low;
    r.cold_zone  = zone_q;
    r.sectors    = pat;
    r.action     = pick_action(pat, low);
    return r;
  endfunction

  // distance for one sweep slot, near or far under the current registers
  function automatic logic [DIST_W-1:0] pick_distance(logic want_near);
    int unsigned hi;
    if (want_near && $urandom_range(99) < 85) begin
      if (secure_dist == 0) return '0;
      if (stop_dist + 1 < secure_dist && $urandom_range(3) != 0)
        return DIST_W'($urandom_range(secure_dist - 1, stop_dist + 1));
      return DIST_W'($urandom_range(secure_dist - 1));
    end
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1, 2: return DIST_W'($urandom);
      default: begin
        hi = secure_dist + 2 * hot_limit + 64;
        if (hi > 65535) hi = 65535;
        return DIST_W'($urandom_range(hi, secure_dist));
      end
    endcase
  endfunction

  // mostly clean servo sweeps with random content, some noise
  task automatic queue_sweeps(int unsigned n_items);
    int unsigned added;
    scan_item_t s;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 12) begin
        s.pos      = $urandom_range(1) ? gen_last : POS_W'($urandom_range(31));
        s.distance = DIST_W'($urandom);
      end else begin
        if (sweep_up) begin
          if (sweep_pos == SLOTS - 1) begin
            sweep_up  = 1'b0;
            sweep_pos--;
            near_mask = 5'($urandom);
          end else sweep_pos++;
        end else begin
          if (sweep_pos == 0) begin
            sweep_up  = 1'b1;
            sweep_pos++;
            near_mask = 5'($urandom);
          end else sweep_pos--;
        end
        s.pos      = POS_W'(sweep_pos);
        s.distance = pick_distance(near_mask[4 - (sweep_pos - SKIP) / SPAN]);
      end
      gen_last = s.pos;
      scan_queue.push_back(s);
      if (s.pos < SLOTS) added++;
    end
  endtask

  task automatic queue_item(logic [POS_W-1:0] pos, logic [DIST_W-1:0] sample_dist);
    scan_item_t s;
    s.pos      = pos;
    s.distance = sample_dist;
    scan_queue.push_back(s);
    gen_last = pos;
  endtask

  // register write through the configuration port
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIST_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NEAR_LIMIT:    secure_dist = value;
      REG_AVG_LIMIT:     hot_limit   = value;
      REG_STOP_DISTANCE: stop_dist   = value;
      default: ;
    endcase
  endtask

  // wait until every sample is in and every result is out
  task automatic wait_idle();
    @(negedge clk);
    while (scan_queue.size() != 0 || in_ch.valid || expected_steer.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(logic [DIST_W-1:0] sec, logic [DIST_W-1:0] hot,
                           logic [DIST_W-1:0] stp, int unsigned idle_pct,
                           int unsigned stall_pct, int unsigned n_items);
    wait_idle();
    write_reg(REG_NEAR_LIMIT, sec);
    write_reg(REG_AVG_LIMIT, hot);
    write_reg(REG_STOP_DISTANCE, stp);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_sweeps(n_items);
  endtask

  // sample driver
  always @(posedge clk) begin : drive_samples
    scan_item_t s;
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.scan_position <= '0;
      in_ch.distance      <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_steer.push_back(steer_predict(in_ch.scan_position, in_ch.distance));
      if (!in_ch.valid || in_ch.ready) begin
        if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s = scan_queue.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.scan_position <= s.pos;
          in_ch.distance      <= s.distance;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    steer_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_steer.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result transaction, action %0d nearest %0d",
                 $realtime, out_ch.action, out_ch.nearest);
      end else begin
        e = expected_steer.pop_front();
        if (out_ch.scan_valid !== e.scan_valid) begin
          err_count++;
          $display("%0t: scan_valid expected %0d actual %0d",
                   $realtime, e.scan_valid, out_ch.scan_valid);
        end
        if (out_ch.nearest !== e.nearest) begin
          err_count++;
          $display("%0t: nearest expected %0d actual %0d",
                   $realtime, e.nearest, out_ch.nearest);
        end
        if (out_ch.cold_zone !== e.cold_zone) begin
          err_count++;
          $display("%0t: cold_zone expected %0d actual %0d",
                   $realtime, e.cold_zone, out_ch.cold_zone);
        end
        if (out_ch.sector_bits !== e.sectors) begin
          err_count++;
          $display("%0t: sector_bits expected %05b actual %05b",
                   $realtime, e.sectors, out_ch.sector_bits);
        end
        if (out_ch.action !== e.action) begin
          err_count++;
          $display("%0t: action expected %0d actual %0d",
                   $realtime, e.action, out_ch.action);
        end
      end
    end
  end

  // reset, directed samples, then register and idling phases
  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // slot thirty-one right after reset and a slot past the store
    queue_item(5'd31, 16'hFFFF);
    queue_item(5'd20, 16'h0000);
    // fill the store, with a repeat in the middle
    for (int i = 0; i < SLOTS; i++) begin
      queue_item(POS_W'(i), (i == 0) ? 16'hFFFF : DIST_W'(300 + i));
      if (i == 3) queue_item(POS_W'(i), 16'd7);
    end
    // first full-store samples: zero distance, repeat, max distance, recovery
    queue_item(5'd0, 16'h0000);
    queue_item(5'd0, 16'h0005);
    queue_item(5'd19, 16'hFFFF);
    queue_item(5'd0, 16'd500);
    queue_sweeps(60);

    run_phase(16'd200, 16'd400, 16'd35, 81, 0, 80);
    run_phase(16'hFFFF, 16'h0000, 16'h0000, 0, 81, 70);
    run_phase(16'h0000, 16'hFFFF, 16'hFFFF, 13, 13, 70);
    // receiver holds off while samples keep coming
    wait_idle();
    hold_request = 1'b1;
    run_phase(16'd1000, 16'd3000, 16'd100, 0, 0, 80);
    run_phase(DIST_W'($urandom_range(2000)), DIST_W'($urandom_range(5000)),
              DIST_W'($urandom_range(300)), 13, 13, 70);
    run_phase(DIST_W'($urandom), DIST_W'($urandom), DIST_W'($urandom), 40, 40, 70);
    wait_idle();

    if (err_count == 0) begin
      $display("lidar_sector_obstacle_steer_test: done, clean");
    end else begin
      $display("lidar_sector_obstacle_steer_test: done, errors");
    end
    $finish;
  end

endmodule
